### hdl/tssc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad check.
package tssc_pkg;

  localparam int unsigned CrcBits    = 8;
  localparam int unsigned CntW       = 4;
  localparam int unsigned TempW      = 16;
  localparam int unsigned ProdW      = 20;

  localparam logic [CrcBits-1:0] CrcPoly      = 8'h8c;
  localparam logic [CntW-1:0]    CntTempLow   = 4'd0;
  localparam logic [CntW-1:0]    CntTempHigh  = 4'd1;
  localparam logic [CntW-1:0]    CntCrcByte   = 4'd8;
  localparam logic [CntW-1:0]    CntIdle      = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } tssc_in_t;

  typedef struct packed {
    logic                    crc_ok;
    logic signed [TempW-1:0] temperature_tenths;
  } tssc_out_t;

  // Reflected CRC-8, LSB first, one data byte.
  function automatic logic [CrcBits-1:0] crc8_byte(input logic [CrcBits-1:0] crc_in,
                                                   input logic [7:0]         data);
    logic [CrcBits-1:0] crc;
    logic               fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = {1'b0, crc[CrcBits-1:1]};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

### hdl/tssc_frame.sv
// Frame tracking, CRC accumulation and temperature scaling for one byte per cycle while take_i is high.
module tssc_frame import tssc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  tssc_in_t  item_i,
  output logic      res_valid_o,
  output tssc_out_t res_o
);

  logic [CntW-1:0]    count_q, count_d, count_eff;
  logic [CrcBits-1:0] crc_q, crc_d, crc_eff;
  logic [7:0]         temp_low_q, temp_low_d;
  logic [7:0]         temp_high_q, temp_high_d;

  logic signed [TempW-1:0] raw;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] biased;
  logic                    ok;

  // A start flag restarts the frame before this byte is counted.
  assign count_eff = item_i.frame_start ? '0 : count_q;
  assign crc_eff   = item_i.frame_start ? '0 : crc_q;

  // raw * 10, then divide by 16 rounding toward zero.
  assign raw    = $signed({temp_high_q, temp_low_q});
  assign prod   = ($signed({{(ProdW-TempW){raw[TempW-1]}}, raw}) <<< 3)
                + ($signed({{(ProdW-TempW){raw[TempW-1]}}, raw}) <<< 1);
  assign biased = prod[ProdW-1] ? prod + ProdW'(15) : prod;
  assign ok     = (crc_eff == item_i.data_byte);

  always_comb begin
    count_d     = count_q;
    crc_d       = crc_q;
    temp_low_d  = temp_low_q;
    temp_high_d = temp_high_q;
    res_valid_o = 1'b0;
    res_o.crc_ok             = ok;
    res_o.temperature_tenths = ok ? biased[ProdW-1 -: TempW] >>> 0 : '0;
    if (take_i) begin
      count_d = count_eff;
      crc_d   = crc_eff;
      if (count_eff < CntCrcByte) begin
        if (count_eff == CntTempLow) begin
          temp_low_d = item_i.data_byte;
        end else if (count_eff == CntTempHigh) begin
          temp_high_d = item_i.data_byte;
        end
        crc_d   = crc8_byte(crc_eff, item_i.data_byte);
        count_d = count_eff + CntW'(1);
      end else if (count_eff == CntCrcByte) begin
        res_valid_o = 1'b1;
        count_d     = CntIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= '0;
      temp_low_q  <= '0;
      temp_high_q <= '0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      temp_low_q  <= temp_low_d;
      temp_high_q <= temp_high_d;
    end
  end

endmodule

### hdl/temp_sensor_scratchpad_check_core.sv
// Top level: input register, frame logic and result register with handshakes.
//
// Scratchpad check for a one-wire temperature sensor.
// Input channel (in_valid_i/in_ready_o/in_data_i): one scratchpad byte per
// transfer; frame_start marks byte 0 and restarts the frame at any point.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per frame,
// issued on the ninth byte, with the CRC-8 check flag and the temperature in
// tenths of a degree (zero when the check fails). Other bytes give nothing.
// A byte that transfers is first held in the input register; its result is
// then registered in the result register once that register is free.
// Throughput: one byte per cycle unless out_ready_i stalls; the frame logic
// between the registers updates the CRC over all eight bits combinationally.
// Stall: when the receiver holds out_ready_i low with a result waiting, the
// input register still takes one more byte; it holds there until the
// result register drains, and in_ready_o drops meanwhile.
// Reset: both registers empty, byte count, CRC and temperature bytes cleared,
// so the first bytes after reset form a frame even without a start flag.
module temp_sensor_scratchpad_check_core import tssc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tssc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tssc_out_t out_data_o
);

  logic      in_valid_q;
  tssc_in_t  in_data_q;
  logic      out_valid_q;
  tssc_out_t out_data_q;
  logic      advance;
  logic      res_valid;
  tssc_out_t res;

  // Stage 1 drains whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  tssc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_valid_q && advance),
    .item_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance && in_valid_q && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
